// ----- sv/orthorhombic_minimum_image_distance_core_assert.svh -----
`ifndef ORTHORHOMBIC_MINIMUM_IMAGE_DISTANCE_CORE_ASSERT_SVH
`define ORTHORHOMBIC_MINIMUM_IMAGE_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define OMID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omid check failed");

// next-cycle implication
`define OMID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("omid check failed");

`endif

// ----- sv/omid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package omid_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned CRD_W      = 31;
  localparam int unsigned DISP_W     = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned REM_W      = 34;
  localparam logic [30:0] BOX_RESET  = 31'd655360;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  typedef logic [NUM_AXES-1:0][CRD_W-1:0] box_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]             neg;
    logic [NUM_AXES-1:0][DISP_W-1:0] mag;
    logic [NUM_AXES-1:0][CRD_W-1:0]  rem;
  } div_t;

  typedef struct packed {
    logic [SUM_W-1:0]                n;
    logic [REM_W-1:0]                rem;
    logic [DISP_W-1:0]               root;
    logic [NUM_AXES-1:0][DISP_W-1:0] disp;
  } sqr_t;

endpackage
`default_nettype wire

// ----- sv/omid_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module omid_div_cell
  import omid_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  en,
  input  box_t box_len,
  input  wire  vld_in,
  input  div_t d_in,
  output logic vld_out,
  output div_t d_out
);

  logic vld_r;
  div_t d_r, d_nxt;
  logic [DISP_W-1:0] trial [NUM_AXES];

  always_comb begin
    d_nxt = d_in;
    for (int a = 0; a < NUM_AXES; a++) begin
      trial[a] = {d_in.rem[a], d_in.mag[a][BIT]};
      if (trial[a] >= {1'b0, box_len[a]}) begin
        d_nxt.rem[a] = CRD_W'(trial[a] - {1'b0, box_len[a]});
      end else begin
        d_nxt.rem[a] = CRD_W'(trial[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule
`default_nettype wire

// ----- sv/omid_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module omid_sqrt_cell
  import omid_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  en,
  input  wire  vld_in,
  input  sqr_t s_in,
  output logic vld_out,
  output sqr_t s_out
);

  logic vld_r;
  sqr_t s_r, s_nxt;
  logic [REM_W+1:0] shifted;
  logic [REM_W+1:0] trial;

  always_comb begin
    s_nxt   = s_in;
    shifted = {s_in.rem, s_in.n[2*STEP+1 -: 2]};
    trial   = {2'b00, s_in.root, 2'b01};
    if (shifted >= trial) begin
      s_nxt.rem  = REM_W'(shifted - trial);
      s_nxt.root = {s_in.root[DISP_W-2:0], 1'b1};
    end else begin
      s_nxt.rem  = REM_W'(shifted);
      s_nxt.root = {s_in.root[DISP_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s_out   = s_r;

endmodule
`default_nettype wire

// ----- sv/orthorhombic_minimum_image_distance_core.sv -----
// channel  direction  payload
// in_      slave      first_x/y/z, second_x/y/z (6 x 31 bits, 192-bit tdata)
// out_     master     disp_x/y/z, dist_res (4 x 32 bits, 128-bit tdata)
// cfg_     slave      index 0..2 selects box_len_x/y/z, 31-bit data
//
// one request per cycle when not stalled: one difference stage, 32 remainder
// cells (one quotient bit each), wrap, square and sum stages, 32 root cells
// a held result stalls the whole cell row; in_tready follows that stall
// rst_n clears valid bits and sets all box lengths to 10.0
`timescale 1ns / 1ps
`default_nettype none
module orthorhombic_minimum_image_distance_core
  import omid_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
  input  wire  [191:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // disp_x, disp_y, disp_z, dist_res
  output logic [127:0] out_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [30:0]  cfg_data
);

  localparam int unsigned DIV_N = DISP_W;
  localparam int unsigned SQR_N = DISP_W;

  logic en;
  box_t box_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= {NUM_AXES{BOX_RESET}};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_X: box_r[0] <= cfg_data;
        REG_BOX_Y: box_r[1] <= cfg_data;
        REG_BOX_Z: box_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // difference stage
  logic vld0_r;
  div_t d0_r, d0_nxt;
  logic signed [DISP_W-1:0] diff [NUM_AXES];

  always_comb begin
    d0_nxt = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = DISP_W'($signed(in_tdata[a*CRD_W +: CRD_W]))
              - DISP_W'($signed(in_tdata[(a+NUM_AXES)*CRD_W +: CRD_W]));
      d0_nxt.neg[a] = diff[a][DISP_W-1];
      d0_nxt.mag[a] = diff[a][DISP_W-1] ? DISP_W'(-diff[a]) : DISP_W'(diff[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= d0_nxt;
    end
  end

  // remainder cells, most significant bit first
  logic vld_d [DIV_N+1];
  div_t dd    [DIV_N+1];
  assign vld_d[0] = vld0_r;
  assign dd[0]    = d0_r;

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    omid_div_cell #(.BIT(DIV_N-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .box_len(box_r),
      .vld_in(vld_d[i]), .d_in(dd[i]),
      .vld_out(vld_d[i+1]), .d_out(dd[i+1])
    );
  end

  // wrap stage
  logic vldw_r;
  logic [NUM_AXES-1:0][DISP_W-1:0] disp_r, disp_nxt;
  logic signed [DISP_W:0] red [NUM_AXES];
  logic signed [DISP_W:0] raw [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if ({dd[DIV_N].rem[a], 1'b0} >= {1'b0, box_r[a]}) begin
        red[a] = $signed({2'b00, dd[DIV_N].rem[a]}) - $signed({2'b00, box_r[a]});
      end else begin
        red[a] = $signed({2'b00, dd[DIV_N].rem[a]});
      end
      if (dd[DIV_N].neg[a]) begin
        red[a] = -red[a];
      end
      raw[a] = dd[DIV_N].neg[a] ? -$signed({1'b0, dd[DIV_N].mag[a]})
                                : $signed({1'b0, dd[DIV_N].mag[a]});
      disp_nxt[a] = (box_r[a] == '0) ? raw[a][DISP_W-1:0] : red[a][DISP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldw_r <= 1'b0;
    end else if (en) begin
      vldw_r <= vld_d[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disp_r <= disp_nxt;
    end
  end

  // square stage
  logic vldq_r;
  logic [NUM_AXES-1:0][DISP_W-1:0] dispq_r;
  logic [NUM_AXES-1:0][SUM_W-1:0]  sq_r;
  logic [DISP_W-1:0] mag_a [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mag_a[a] = disp_r[a][DISP_W-1] ? DISP_W'(-disp_r[a]) : disp_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldq_r <= 1'b0;
    end else if (en) begin
      vldq_r <= vldw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dispq_r <= disp_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_r[a] <= SUM_W'(mag_a[a]) * SUM_W'(mag_a[a]);
      end
    end
  end

  // sum stage
  logic vlds_r;
  sqr_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlds_r <= 1'b0;
    end else if (en) begin
      vlds_r <= vldq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.n    <= sq_r[0] + sq_r[1] + sq_r[2];
      s0_r.rem  <= '0;
      s0_r.root <= '0;
      s0_r.disp <= dispq_r;
    end
  end

  // root cells, two radicand bits each
  logic vld_s [SQR_N+1];
  sqr_t ss    [SQR_N+1];
  assign vld_s[0] = vlds_r;
  assign ss[0]    = s0_r;

  for (genvar i = 0; i < SQR_N; i++) begin : g_sqr
    omid_sqrt_cell #(.STEP(SQR_N-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(vld_s[i]), .s_in(ss[i]),
      .vld_out(vld_s[i+1]), .s_out(ss[i+1])
    );
  end

  assign out_tvalid = vld_s[SQR_N];
  assign out_tdata  = {ss[SQR_N].root, ss[SQR_N].disp[2], ss[SQR_N].disp[1],
                       ss[SQR_N].disp[0]};

endmodule
`default_nettype wire

// ----- sv/omid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "orthorhombic_minimum_image_distance_core_assert.svh"
module omid_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [127:0] out_tdata,
  input wire         cfg_valid,
  input wire         cfg_ready
);

  `OMID_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `OMID_ASSERT_NOW(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready)
  `OMID_ASSERT_NOW(a_empty_takes_in, !out_tvalid, in_tready)
  `OMID_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind orthorhombic_minimum_image_distance_core omid_checker u_omid_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ----- test/orthorhombic_minimum_image_distance_core_checker.sv -----
`timescale 1ns / 1ps
module orthorhombic_minimum_image_distance_core_checker
  import omid_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [191:0] in_tdata,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [127:0] out_tdata,
  input  wire          cfg_valid,
  input  wire          cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [30:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [31:0] disp [3];
    logic [31:0] span;
  } image_t;

  logic [30:0] box_len [3];
  image_t      image_q [$];

  function automatic longint signed fold_axis(longint signed d, longint unsigned len);
    longint unsigned mag, r;
    longint signed red;
    if (len == 0) return d;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    r = mag % len;
    red = (2 * r >= len) ? longint'(r) - longint'(len) : longint'(r);
    return (d < 0) ? -red : red;
  endfunction

  function automatic logic [31:0] int_root(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return (res > 64'hFFFFFFFF) ? 32'hFFFFFFFF : res[31:0];
  endfunction

  function automatic image_t predict_image(logic [191:0] d);
    image_t e;
    longint signed a, b, w;
    logic [63:0] sum;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      a = longint'(signed'(d[31*k +: 31]));
      b = longint'(signed'(d[31*(k+3) +: 31]));
      w = fold_axis(a - b, longint'({33'd0, box_len[k]}));
      e.disp[k] = w[31:0];
      if (w < 0) w = -w;
      sum = sum + 64'(w) * 64'(w);
    end
    e.span = int_root(sum);
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = image_q.size();

  always @(posedge clk) begin
    image_t e;
    if (!rst_n) begin
      box_len[0] <= BOX_RESET;
      box_len[1] <= BOX_RESET;
      box_len[2] <= BOX_RESET;
      fail_count = 0;
      image_q.delete();
    end else begin
      if (in_tvalid && in_tready) image_q.insert(image_q.size(), predict_image(in_tdata));
      if (out_tvalid && out_tready) begin
        if (image_q.size() == 0) begin
          report_mismatch("unexpected request", out_tdata[31:0], 32'd0);
        end else begin
          e = image_q.pop_front();
          for (int k = 0; k < 3; k++)
            if (out_tdata[32*k +: 32] !== e.disp[k])
              report_mismatch($sformatf("disp axis %0d", k), out_tdata[32*k +: 32], e.disp[k]);
          if (out_tdata[127:96] !== e.span)
            report_mismatch("dist_res", out_tdata[127:96], e.span);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_X: box_len[0] <= cfg_data;
          REG_BOX_Y: box_len[1] <= cfg_data;
          REG_BOX_Z: box_len[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- test/orthorhombic_minimum_image_distance_core_test.sv -----
`timescale 1ns / 1ps
module orthorhombic_minimum_image_distance_core_test;
  import omid_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  wire          in_tready;
  logic [191:0] in_tdata = '0;
  wire          out_tvalid;
  logic         out_tready = 0;
  wire  [127:0] out_tdata;
  logic         cfg_valid = 0;
  wire          cfg_ready;
  logic [1:0]   cfg_index = REG_BOX_X;
  logic [30:0]  cfg_data = '0;
  int           fail_count, pending;
  int           sent = 0, idle = 0;

  always #5 clk = ~clk;

  orthorhombic_minimum_image_distance_core i_dut (.*);

  orthorhombic_minimum_image_distance_core_checker i_chk (.*);

  function automatic logic [30:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 31'h3FFFFFFF;
      1: return 31'h40000000;
      2: return 31'($urandom_range(0, 2000000)) - 31'd1000000;
      default: return 31'($urandom);
    endcase
  endfunction

  // valid stays high after the request; settle() or the next gap drops it
  task automatic send_pair(logic [30:0] c0, c1, c2, c3, c4, c5);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {6'd0, c5, c4, c3, c2, c1, c0};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    send_pair(pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic write_box(logic [1:0] idx, logic [30:0] len);
    cfg_index <= idx;
    cfg_data <= len;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_boxes(logic [30:0] bx, by, bz);
    settle();
    write_box(REG_BOX_X, bx);
    write_box(REG_BOX_Y, by);
    write_box(REG_BOX_Z, bz);
    cfg_valid <= 0;
  endtask

  // receiver stalls
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle <= 0;
    else
      idle <= idle + 1;
    if (idle >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: reset boxes, exact halves, extremes
    send_pair(31'd327680, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 31'd327680, 31'd327680, 0);
    send_pair(31'd327679, -31'd327680, 31'd655360, 0, 0, 0);
    send_pair(31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF, 31'h40000000, 31'h40000000, 31'h40000000);
    send_pair(31'h40000000, 31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF);
    send_pair(0, 0, 0, 0, 0, 0);
    set_boxes(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_pair(31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF, 31'h40000000, 31'h40000000, 31'h40000000);
    send_pair(31'h40000000, 31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF);
    set_boxes(31'd1, 31'd2, 31'd3);
    send_pair(31'd1, 31'd1, 31'd1, 0, 0, 0);
    send_pair(31'd5, 31'd7, 31'd11, 0, 0, 0);
    set_boxes(0, 0, 0);
    send_pair(31'h3FFFFFFF, 31'h40000000, 31'd12345, 31'h40000000, 31'h3FFFFFFF, 31'd0);
    send_pair(31'h40000000, 31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, 31'h3FFFFFFF);
    // random phases over several box settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_boxes(BOX_RESET, BOX_RESET, BOX_RESET);
        1: set_boxes(31'h7FFFFFFF, 31'd1, 31'h40000000);
        2: set_boxes(0, 31'd65536, 31'h7FFFFFFF);
        default: set_boxes(31'($urandom), 31'($urandom_range(1, 5000000)), 31'($urandom));
      endcase
      for (int n = 0; n < 125; n++) begin
        send_random();
        if (n == 60 && phase == 3) settle();
      end
    end
    settle();
    $display("covered %0d atom pairs over reset, extreme, zero and random box lengths", sent);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
